// File: sv/frsp_pkg.sv
package frsp_pkg;

  localparam int unsigned ActW = 41;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIR_INIT,
    ST_MIN_DIV,
    ST_MAX_CALC,
    ST_WANT,
    ST_BASE_DIV,
    ST_BASE_DONE,
    ST_CAND_NEXT,
    ST_CNT_DIV,
    ST_DEN_MUL,
    ST_RATE_DIV,
    ST_ACT_MUL,
    ST_ACT_DIV,
    ST_CMP,
    ST_DIR_DONE,
    ST_OUT
  } state_e;

  // Why a base division is being run.
  typedef enum logic [1:0] {
    BASE_WANT,
    BASE_MIN,
    BASE_MAX
  } base_e;

  typedef struct packed {
    logic [31:0] step_hz;
    logic [15:0] rate;
    logic [31:0] count;
    logic [ActW-1:0] actual_us;
  } plan_t;

  typedef struct packed {
    logic        status;
    logic [31:0] up_step_hz;
    logic [31:0] down_step_hz;
    logic [15:0] up_rate;
    logic [15:0] down_rate;
    logic [31:0] up_count;
    logic [31:0] down_count;
    logic [ActW-1:0] up_actual_us;
    logic [ActW-1:0] down_actual_us;
  } result_t;

  typedef struct packed {
    logic [31:0] start_freq_hz;
    logic [31:0] stop_freq_hz;
    logic [31:0] up_time_ms;
    logic [31:0] down_time_ms;
    logic [31:0] step_target;
  } request_t;

  localparam logic [0:0] RegDefaultStepTarget = 1'b0;
  localparam logic [0:0] RegMaxFrequencyHz    = 1'b1;

endpackage

// File: sv/frsp_if.sv
interface frsp_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: sv/frsp_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, 64-bit operands.
module frsp_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [63:0] den_i,
  output logic        done_o,
  output logic [63:0] quo_o,
  output logic [63:0] rem_o
);

  logic [63:0] quo_q, quo_d, rem_q, rem_d, den_q, den_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [64:0] trial;

  assign trial = {rem_q, quo_q[63]} - {1'b0, den_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift one numerator bit in, subtract if it fits
      if (!trial[64]) begin
        rem_d = trial[63:0];
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = {rem_q[62:0], quo_q[63]};
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

// File: sv/frequency_ramp_sweep_planner_top.sv
// Sweep ramp planner. One request is taken at a time; in_req.ready is high
// only while the sequencer is idle, so the next request may be taken while the
// previous plan still waits on out_res. Both directions are planned through
// one shared 64-bit serial divider. Per direction there are four bound/base
// divisions plus, for each of up to eight step candidates, three divisions
// (count, rate, actual time); rejected requests finish early. Configuration
// writes take effect at once and must only be made while the block is idle.
module frequency_ramp_sweep_planner_top #(
  parameter int unsigned RATE_LIMIT = 65535
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  frsp_if.sink        in_req,
  frsp_if.source      out_res
);

  localparam logic [63:0] MinDen = 64'(4 * RATE_LIMIT);
  localparam logic [63:0] RateMax = 64'(RATE_LIMIT);

  // configuration registers
  logic [31:0] dflt_q, maxf_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dflt_q <= 32'd1000;
      maxf_q <= 32'd400000000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        frsp_pkg::RegDefaultStepTarget: dflt_q <= cfg_wdata_i;
        frsp_pkg::RegMaxFrequencyHz:    maxf_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  frsp_pkg::state_e state_q, state_d;
  frsp_pkg::base_e  bsel_q, bsel_d;
  frsp_pkg::request_t req_q;
  frsp_pkg::result_t  res_q, res_d;
  frsp_pkg::plan_t    best_q, best_d, cand_q, cand_d, up_q, up_d;
  logic        dir_q, dir_d, have_q, have_d, rej_q, rej_d, ovalid_q, ovalid_d;
  logic [63:0] span_q, span_d, req_ns_q, req_ns_d, req_us_q, req_us_d;
  logic [63:0] min_q, min_d, max_q, max_d, want_q, want_d, den_q, den_d;
  logic [31:0] cl_q [8];
  logic [31:0] cl_d [8];
  logic [3:0]  n_q, n_d, i_q, i_d;

  // shared divider
  logic        dv_start, dv_done;
  logic [63:0] dv_num, dv_den, dv_quo, dv_rem, dv_ceil;
  frsp_div u_div (
    .clk_i, .rst_ni, .start_i(dv_start), .num_i(dv_num), .den_i(dv_den),
    .done_o(dv_done), .quo_o(dv_quo), .rem_o(dv_rem)
  );
  assign dv_ceil = dv_quo + {63'd0, dv_rem != '0};

  logic [31:0] time_ms;
  assign time_ms = dir_q ? req_q.down_time_ms : req_q.up_time_ms;

  // shared arithmetic for candidate scoring
  logic [63:0] ce, be, act_ext, bact_ext;
  assign act_ext  = {23'd0, cand_q.actual_us};
  assign bact_ext = {23'd0, best_q.actual_us};
  assign ce = (act_ext >= req_us_q) ? act_ext - req_us_q : req_us_q - act_ext;
  assign be = (bact_ext >= req_us_q) ? bact_ext - req_us_q : req_us_q - bact_ext;

  logic [63:0] prod;
  assign prod = 64'(den_q * {48'd0, cand_q.rate});

  assign in_req.ready = (state_q == frsp_pkg::ST_IDLE);
  assign out_res.valid = ovalid_q;
  assign out_res.data  = res_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      frsp_pkg::ST_IDLE:     if (in_req.valid) state_d = frsp_pkg::ST_CHECK;
      frsp_pkg::ST_CHECK:
        state_d = (req_q.start_freq_hz >= req_q.stop_freq_hz ||
                   req_q.stop_freq_hz > maxf_q) ? frsp_pkg::ST_OUT
                                                 : frsp_pkg::ST_DIR_INIT;
      frsp_pkg::ST_DIR_INIT:
        state_d = (time_ms == '0) ? frsp_pkg::ST_OUT : frsp_pkg::ST_MIN_DIV;
      frsp_pkg::ST_MIN_DIV:  if (dv_done) state_d = frsp_pkg::ST_MAX_CALC;
      frsp_pkg::ST_MAX_CALC:
        state_d = (min_q == '0 || min_q > max_d) ? frsp_pkg::ST_OUT
                                                  : frsp_pkg::ST_WANT;
      frsp_pkg::ST_WANT:     state_d = frsp_pkg::ST_BASE_DIV;
      frsp_pkg::ST_BASE_DIV: if (dv_done) state_d = frsp_pkg::ST_BASE_DONE;
      frsp_pkg::ST_BASE_DONE:
        state_d = (bsel_q == frsp_pkg::BASE_MAX) ? frsp_pkg::ST_CAND_NEXT
                                                  : frsp_pkg::ST_BASE_DIV;
      frsp_pkg::ST_CAND_NEXT:
        state_d = (i_q >= n_q) ? frsp_pkg::ST_DIR_DONE
                : (cl_q[i_q[2:0]] == '0) ? frsp_pkg::ST_CAND_NEXT
                                         : frsp_pkg::ST_CNT_DIV;
      frsp_pkg::ST_CNT_DIV:
        if (dv_done) state_d = (dv_ceil == '0) ? frsp_pkg::ST_CAND_NEXT
                                               : frsp_pkg::ST_DEN_MUL;
      frsp_pkg::ST_DEN_MUL:  state_d = frsp_pkg::ST_RATE_DIV;
      frsp_pkg::ST_RATE_DIV:
        if (dv_done) state_d = (dv_quo < 64'd1 || dv_quo > RateMax)
                               ? frsp_pkg::ST_CAND_NEXT : frsp_pkg::ST_ACT_MUL;
      frsp_pkg::ST_ACT_MUL:  state_d = frsp_pkg::ST_ACT_DIV;
      frsp_pkg::ST_ACT_DIV:  if (dv_done) state_d = frsp_pkg::ST_CMP;
      frsp_pkg::ST_CMP:      state_d = frsp_pkg::ST_CAND_NEXT;
      frsp_pkg::ST_DIR_DONE:
        state_d = (!have_q || dir_q) ? frsp_pkg::ST_OUT : frsp_pkg::ST_DIR_INIT;
      frsp_pkg::ST_OUT:      if (!ovalid_q) state_d = frsp_pkg::ST_IDLE;
      default:               state_d = frsp_pkg::ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    bsel_d = bsel_q; res_d = res_q; best_d = best_q; cand_d = cand_q;
    up_d = up_q; dir_d = dir_q; have_d = have_q; rej_d = rej_q;
    ovalid_d = ovalid_q; span_d = span_q; req_ns_d = req_ns_q;
    req_us_d = req_us_q; min_d = min_q; max_d = max_q; want_d = want_q;
    den_d = den_q; cl_d = cl_q; n_d = n_q; i_d = i_q;
    dv_start = 1'b0; dv_num = '0; dv_den = 64'd1;
    if (out_res.valid && out_res.ready) ovalid_d = 1'b0;
    unique case (state_q)
      frsp_pkg::ST_IDLE: begin
        dir_d = 1'b0;
        rej_d = 1'b1;
      end
      frsp_pkg::ST_CHECK:
        span_d = {32'd0, req_q.stop_freq_hz - req_q.start_freq_hz};
      frsp_pkg::ST_DIR_INIT: begin
        req_ns_d = 64'({32'd0, time_ms} * 64'd1000000);
        req_us_d = 64'({32'd0, time_ms} * 64'd1000);
        have_d = 1'b0;
        dv_start = 1'b1;
        dv_num = 64'({32'd0, time_ms} * 64'd1000000);
        dv_den = MinDen;
      end
      frsp_pkg::ST_MIN_DIV: if (dv_done) min_d = dv_ceil;
      frsp_pkg::ST_MAX_CALC: begin
        max_d = (req_ns_q >> 2) > span_q ? span_q : (req_ns_q >> 2);
        want_d = (req_q.step_target == '0) ? {32'd0, dflt_q}
                                           : {32'd0, req_q.step_target};
      end
      frsp_pkg::ST_WANT: begin
        if (want_q < min_q) want_d = min_q;
        else if (want_q > max_q) want_d = max_q;
        bsel_d = frsp_pkg::BASE_WANT;
        n_d = '0;
        i_d = '0;
        for (int k = 0; k < 8; k++) cl_d[k] = '0;
        dv_start = 1'b1;
        dv_num = span_q;
        dv_den = (want_q < min_q) ? min_q : (want_q > max_q) ? max_q : want_q;
      end
      frsp_pkg::ST_BASE_DONE: begin
        // candidate list: each base; base-1 (base>1) for want/min; base+1 (base<span) for want/max; then 1 if room
        cl_d[n_q[2:0]] = dv_ceil[31:0];
        n_d = n_q + 4'd1;
        unique case (bsel_q)
          frsp_pkg::BASE_WANT: begin
            if (dv_ceil > 64'd1) begin
              cl_d[n_d[2:0]] = dv_ceil[31:0] - 32'd1; n_d = n_d + 4'd1;
            end
            if (dv_ceil < span_q) begin
              cl_d[n_d[2:0]] = dv_ceil[31:0] + 32'd1; n_d = n_d + 4'd1;
            end
            bsel_d = frsp_pkg::BASE_MIN;
            dv_start = 1'b1; dv_num = span_q; dv_den = min_q;
          end
          frsp_pkg::BASE_MIN: begin
            if (dv_ceil > 64'd1) begin
              cl_d[n_d[2:0]] = dv_ceil[31:0] - 32'd1; n_d = n_d + 4'd1;
            end
            bsel_d = frsp_pkg::BASE_MAX;
            dv_start = 1'b1; dv_num = span_q; dv_den = max_q;
          end
          default: begin
            if (dv_ceil < span_q) begin
              cl_d[n_d[2:0]] = dv_ceil[31:0] + 32'd1; n_d = n_d + 4'd1;
            end
            if (n_d < 4'd8) begin
              cl_d[n_d[2:0]] = 32'd1; n_d = n_d + 4'd1;
            end
          end
        endcase
      end
      frsp_pkg::ST_CAND_NEXT: begin
        if (i_q < n_q) begin
          i_d = i_q + 4'd1;
          cand_d.step_hz = cl_q[i_q[2:0]];
          if (cl_q[i_q[2:0]] != '0) begin
            dv_start = 1'b1; dv_num = span_q; dv_den = {32'd0, cl_q[i_q[2:0]]};
          end
        end
      end
      frsp_pkg::ST_CNT_DIV: if (dv_done) cand_d.count = dv_ceil[31:0];
      frsp_pkg::ST_DEN_MUL: begin
        den_d = {30'd0, cand_q.count, 2'b00};
        dv_start = 1'b1;
        dv_num = req_ns_q + {31'd0, cand_q.count, 1'b0};
        dv_den = {30'd0, cand_q.count, 2'b00};
      end
      frsp_pkg::ST_RATE_DIV: if (dv_done) cand_d.rate = dv_quo[15:0];
      frsp_pkg::ST_ACT_MUL: begin
        dv_start = 1'b1; dv_num = prod + 64'd500; dv_den = 64'd1000;
      end
      frsp_pkg::ST_ACT_DIV: if (dv_done) cand_d.actual_us = dv_quo[frsp_pkg::ActW-1:0];
      frsp_pkg::ST_CMP: begin
        if (!have_q || ((ce != be) ? (ce < be) : (cand_q.count > best_q.count))) begin
          best_d = cand_q;
          have_d = 1'b1;
        end
      end
      frsp_pkg::ST_DIR_DONE: begin
        if (have_q && !dir_q) begin
          up_d = best_q;
          dir_d = 1'b1;
        end else if (have_q) begin
          rej_d = 1'b0;
        end
      end
      frsp_pkg::ST_OUT: begin
        if (!ovalid_q) begin
          ovalid_d = 1'b1;
          res_d = '0;
          res_d.status = rej_q;
          if (!rej_q) begin
            res_d.up_step_hz = up_q.step_hz;     res_d.down_step_hz = best_q.step_hz;
            res_d.up_rate = up_q.rate;           res_d.down_rate = best_q.rate;
            res_d.up_count = up_q.count;         res_d.down_count = best_q.count;
            res_d.up_actual_us = up_q.actual_us; res_d.down_actual_us = best_q.actual_us;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= frsp_pkg::ST_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == frsp_pkg::ST_IDLE && in_req.valid) req_q <= in_req.data;
    bsel_q <= bsel_d; res_q <= res_d; best_q <= best_d; cand_q <= cand_d;
    up_q <= up_d; dir_q <= dir_d; have_q <= have_d; rej_q <= rej_d;
    span_q <= span_d; req_ns_q <= req_ns_d; req_us_q <= req_us_d;
    min_q <= min_d; max_q <= max_d; want_q <= want_d; den_q <= den_d;
    cl_q <= cl_d; n_q <= n_d; i_q <= i_d;
  end

endmodule

// File: sv/frsp_checker.sv
module frsp_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input frsp_pkg::result_t out_data
);

  // a rejected result carries zeros
  a_rej_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_data.status) |-> (out_data.up_count == '0 &&
      out_data.down_count == '0 && out_data.up_rate == '0))
    else $error("rejected result not cleared");

  // an accepted plan has legal rates
  a_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_data.status) |-> (out_data.up_rate != '0 &&
      out_data.down_rate != '0 && out_data.up_count != '0))
    else $error("plan with zero rate");

  // accepting a request drops ready next cycle
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && in_ready) |=> !in_ready) else $error("ready after accept");

  // result holds while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result dropped");

endmodule

bind frequency_ramp_sweep_planner_top frsp_checker u_frsp_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid(in_req.valid), .in_ready(in_req.ready),
  .out_valid(out_res.valid), .out_ready(out_res.ready),
  .out_data(out_res.data)
);
